[hdl/ppwm_pkg.sv]
// ----------------------------------------------------------------------------
// ppwm_pkg
// Shared widths, register indexes, reset values and types for the PID
// position to PWM duty controller.
// ----------------------------------------------------------------------------
package ppwm_pkg;

   localparam int GAIN_W      = 24;
   localparam int POS_W       = 32;
   localparam int ERR_W       = 34;
   localparam int DLT_W       = 35;
   localparam int PTERM_W     = 59;
   localparam int DTERM_W     = 60;
   localparam int ITERM_W     = 59;
   localparam int PD_W        = 61;
   localparam int ACC_W       = 64;
   localparam int DRIVE_OUT_W = 10;
   localparam int DUTY_W      = 7;
   localparam int PCT_SCALE   = 100;
   localparam int RECIP_SHIFT = 32;
   localparam int CSR_IDX_W   = 2;

   localparam int DEF_GAIN_FRAC_BITS = 20;
   localparam int DEF_OUTPUT_MAX     = 999;
   localparam int DEF_QUEUE_DEPTH    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd2;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd104858;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd10486;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd1049;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } ppwm_gains_type;

   // proportional plus derivative sum, and integral increment
   typedef struct packed {
      logic signed [PD_W-1:0]    pd_sum;
      logic signed [ITERM_W-1:0] i_term;
   } ppwm_entry_type;

endpackage

[hdl/pid_position_to_pwm_duty.sv]
// ----------------------------------------------------------------------------
// pid_position_to_pwm_duty
// PID position controller giving a clamped drive level and a PWM duty.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | target_position, measured_position
//   rsp     | out       | rsp_valid/ready    | drive_level, duty_percent
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One tick per cycle sustained while rsp_ready holds. A req transfer passes
// the error and multiplier registers and the queue write in the front, then
// three back stages (integral add and clamp, reciprocal multiply, duty
// correction) before rsp valid. The integral and previous error update once
// per tick. Synchronous reset clears gains to defaults, integral and error.
// A stalled rsp fills the back stages, then the queue; req_ready drops once
// the queue and the front stages in flight reach the queue depth.
// ----------------------------------------------------------------------------
module pid_position_to_pwm_duty #(
   parameter int GAIN_FRAC_BITS = ppwm_pkg::DEF_GAIN_FRAC_BITS,
   parameter int OUTPUT_MAX     = ppwm_pkg::DEF_OUTPUT_MAX,
   parameter int QUEUE_DEPTH    = ppwm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ppwm_pkg::POS_W-1:0]   req_target_position,
   input  logic        [ppwm_pkg::POS_W-1:0]   req_measured_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ppwm_pkg::DRIVE_OUT_W-1:0]    rsp_drive_level,
   output logic [ppwm_pkg::DUTY_W-1:0]         rsp_duty_percent,
   input  logic                                csr_write_enable,
   input  logic [ppwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppwm_pkg::GAIN_W-1:0]         csr_write_data
);
   import ppwm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ppwm_gains_type  gains_ff;
   ppwm_gains_type  gains_in;
   logic            push;
   logic            pop;
   ppwm_entry_type  push_entry;
   ppwm_entry_type  head_entry;
   logic [CNT_W-1:0] q_count;

   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROP_GAIN:  gains_in.prop  = csr_write_data;
            CSR_INTEG_GAIN: gains_in.integ = csr_write_data;
            CSR_DERIV_GAIN: gains_in.deriv = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= PROP_GAIN_RST;
         gains_ff.integ <= INTEG_GAIN_RST;
         gains_ff.deriv <= DERIV_GAIN_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

   ppwm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_target_position  (req_target_position),
      .req_measured_position(req_measured_position),
      .gains                (gains_ff),
      .q_count              (q_count),
      .push                 (push),
      .push_entry           (push_entry)
   );

   ppwm_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .q_count   (q_count)
   );

   ppwm_back #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
      .OUTPUT_MAX    (OUTPUT_MAX),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .q_count         (q_count),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_level (rsp_drive_level),
      .rsp_duty_percent(rsp_duty_percent)
   );

   // credit must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> q_count < CNT_W'(QUEUE_DEPTH))
      else $error("queue push when full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_count != '0)
      else $error("queue pop when empty");

   // front never stalls: every transfer passes the error and multiplier registers, then pushes
   a_front_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 push)
      else $error("accepted tick lost in front");

endmodule

[hdl/ppwm_front.sv]
// ----------------------------------------------------------------------------
// ppwm_front
// Takes control ticks, forms error and error change, multiplies by the gains
// and pushes the terms into the queue. Credit-based ready.
// ----------------------------------------------------------------------------
module ppwm_front #(
   parameter int QUEUE_DEPTH = ppwm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ppwm_pkg::POS_W-1:0]   req_target_position,
   input  logic        [ppwm_pkg::POS_W-1:0]   req_measured_position,
   input  ppwm_pkg::ppwm_gains_type            gains,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
   output logic                                push,
   output ppwm_pkg::ppwm_entry_type            push_entry
);
   import ppwm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                      accept;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [DLT_W-1:0]   dlt_in;
   logic [CNT_W:0]            used;

   logic                      v1_ff;
   logic                      v2_ff;
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [ERR_W-1:0]   err1_ff;
   logic signed [DLT_W-1:0]   dlt1_ff;
   logic signed [PTERM_W-1:0] p2_ff;
   logic signed [DTERM_W-1:0] d2_ff;
   logic signed [ITERM_W-1:0] i2_ff;

   // queue slots already taken or promised to items in flight
   assign used      = {1'b0, q_count} + (CNT_W+1)'(v1_ff) + (CNT_W+1)'(v2_ff);
   assign req_ready = used < (CNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign err_in = {{(ERR_W-POS_W){req_target_position[POS_W-1]}}, req_target_position}
                 - {{(ERR_W-POS_W){1'b0}}, req_measured_position};
   assign dlt_in = {err_in[ERR_W-1], err_in} - {last_err_ff[ERR_W-1], last_err_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         last_err_ff <= '0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         if (accept) begin
            last_err_ff <= err_in;
         end
      end
      err1_ff <= err_in;
      dlt1_ff <= dlt_in;
      p2_ff   <= $signed({1'b0, gains.prop})  * err1_ff;
      d2_ff   <= $signed({1'b0, gains.deriv}) * dlt1_ff;
      i2_ff   <= $signed({1'b0, gains.integ}) * err1_ff;
   end

   assign push              = v2_ff;
   assign push_entry.pd_sum = {{(PD_W-PTERM_W){p2_ff[PTERM_W-1]}}, p2_ff}
                            + {{(PD_W-DTERM_W){d2_ff[DTERM_W-1]}}, d2_ff};
   assign push_entry.i_term = i2_ff;

endmodule

[hdl/ppwm_queue.sv]
// ----------------------------------------------------------------------------
// ppwm_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module ppwm_queue #(
   parameter int QUEUE_DEPTH = ppwm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  ppwm_pkg::ppwm_entry_type            push_entry,
   input  logic                                pop,
   output ppwm_pkg::ppwm_entry_type            head_entry,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count
);
   import ppwm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ppwm_entry_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = entry_ff[rd_ptr_ff];
   assign q_count    = count_ff;

endmodule

[hdl/ppwm_back.sv]
// ----------------------------------------------------------------------------
// ppwm_back
// Adds the integral, clamps to a drive level, scales it to a duty percentage
// and updates the integral. Three stages, the last being the output register.
// ----------------------------------------------------------------------------
module ppwm_back #(
   parameter int GAIN_FRAC_BITS = ppwm_pkg::DEF_GAIN_FRAC_BITS,
   parameter int OUTPUT_MAX     = ppwm_pkg::DEF_OUTPUT_MAX,
   parameter int QUEUE_DEPTH    = ppwm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ppwm_pkg::ppwm_entry_type                head_entry,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]        q_count,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ppwm_pkg::DRIVE_OUT_W-1:0]        rsp_drive_level,
   output logic [ppwm_pkg::DUTY_W-1:0]             rsp_duty_percent
);
   import ppwm_pkg::*;

   localparam int DRIVE_W = $clog2(OUTPUT_MAX + 1);
   localparam int HI_W    = ACC_W - GAIN_FRAC_BITS;
   localparam logic [63:0] RECIP_K =
      64'(PCT_SCALE) * ((64'd1 << RECIP_SHIFT) / 64'(OUTPUT_MAX));
   localparam int K_W    = $clog2(RECIP_K + 1);
   localparam int PROD_W = DRIVE_W + K_W;
   localparam int X_W    = DRIVE_W + DUTY_W;

   logic                      s1_ready;
   logic                      s2_ready;
   logic                      s3_ready;
   logic signed [ACC_W:0]     sum_wide;
   logic signed [ACC_W:0]     acc_wide;
   logic signed [ACC_W-1:0]   sum_sat;
   logic signed [ACC_W-1:0]   integ_in;
   logic [HI_W-1:0]           sum_hi;
   logic [DRIVE_W-1:0]        drive_in;
   logic [DUTY_W-1:0]         q0;
   logic [X_W-1:0]            scaled;
   logic [X_W-1:0]            back_mul;
   logic [X_W-1:0]            remainder;
   logic [DUTY_W-1:0]         duty_in;

   logic signed [ACC_W-1:0]   integ_ff;
   logic                      b1_v_ff;
   logic [DRIVE_W-1:0]        b1_drive_ff;
   logic                      b2_v_ff;
   logic [DRIVE_W-1:0]        b2_drive_ff;
   logic [PROD_W-1:0]         b2_prod_ff;
   logic                      rsp_valid_ff;
   logic [DRIVE_OUT_W-1:0]    rsp_drive_ff;
   logic [DUTY_W-1:0]         rsp_duty_ff;

   assign s3_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready = !b2_v_ff || s3_ready;
   assign s1_ready = !b1_v_ff || s2_ready;
   assign pop      = (q_count != '0) && s1_ready;

   always_comb begin
      sum_wide = {integ_ff[ACC_W-1], integ_ff}
               + {{(ACC_W+1-PD_W){head_entry.pd_sum[PD_W-1]}}, head_entry.pd_sum};
      acc_wide = {integ_ff[ACC_W-1], integ_ff}
               + {{(ACC_W+1-ITERM_W){head_entry.i_term[ITERM_W-1]}}, head_entry.i_term};
      // saturate at the signed 64-bit limits
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
      if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
         integ_in = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         integ_in = acc_wide[ACC_W-1:0];
      end
      sum_hi = sum_sat[ACC_W-1:GAIN_FRAC_BITS];
      if (sum_sat[ACC_W-1]) begin
         drive_in = '0;
      end else if (sum_hi > HI_W'(OUTPUT_MAX)) begin
         drive_in = DRIVE_W'(OUTPUT_MAX);
      end else begin
         drive_in = DRIVE_W'(sum_hi);
      end
   end

   // reciprocal estimate is low by at most one; one compare corrects it
   always_comb begin
      q0        = DUTY_W'(b2_prod_ff >> RECIP_SHIFT);
      scaled    = X_W'(b2_drive_ff) * X_W'(PCT_SCALE);
      back_mul  = X_W'(q0) * X_W'(OUTPUT_MAX);
      remainder = scaled - back_mul;
      duty_in   = (remainder >= X_W'(OUTPUT_MAX)) ? q0 + DUTY_W'(1) : q0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            integ_ff <= integ_in;
         end
         if (s1_ready) begin
            b1_v_ff <= pop;
         end
         if (s2_ready) begin
            b2_v_ff <= b1_v_ff;
         end
         if (s3_ready) begin
            rsp_valid_ff <= b2_v_ff;
         end
      end
      if (pop) begin
         b1_drive_ff <= drive_in;
      end
      if (s2_ready && b1_v_ff) begin
         b2_drive_ff <= b1_drive_ff;
         b2_prod_ff  <= PROD_W'(b1_drive_ff) * PROD_W'(RECIP_K);
      end
      if (s3_ready && b2_v_ff) begin
         rsp_drive_ff <= DRIVE_OUT_W'(b2_drive_ff);
         rsp_duty_ff  <= duty_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_level  = rsp_drive_ff;
   assign rsp_duty_percent = rsp_duty_ff;

endmodule

[test/tb_pid_position_to_pwm_duty.sv]
// ----------------------------------------------------------------------------
// tb_pid_position_to_pwm_duty
// Self-checking bench for the PID position controller. A predictor tracks
// the gains, integral and previous error, and works out drive level and duty
// for every tick transfer. The bench checks each response against the oldest
// prediction. Stimulus is a short list of corner ticks, then phases at
// different gain settings: small errors around the setpoint, full-range
// words and corner words. A final pass drives the integral into both
// saturation limits. Handshakes stall at random until the last third of items.
// ----------------------------------------------------------------------------
module tb_pid_position_to_pwm_duty;
   timeunit 1ns;
   timeprecision 1ps;

   import ppwm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [GAIN_W-1:0] GAIN_FULL = '1;
   localparam int ITEMS_PLANNED = 790;
   localparam longint ERR_TOP    = 64'sd2147483647;
   localparam longint ERR_BOTTOM = -64'sd6442450943;
   localparam longint WORD_LOW   = -64'sd2147483648;
   localparam longint WORD_SPAN  = 64'sd4294967295;
   localparam longint I_DRIFT    = 64'sd2147483648;
   localparam longint I_SETTLED  = 64'sd33554432;

   typedef struct packed {
      logic [DRIVE_OUT_W-1:0] drive;
      logic [DUTY_W-1:0]      duty;
   } drive_duty_type;

   class pwm_drive_board;
      logic [GAIN_W-1:0] kp, ki, kd;
      longint integral, prev_err;
      drive_duty_type drive_due[$];
      int fails;

      function new();
         kp = PROP_GAIN_RST;
         ki = INTEG_GAIN_RST;
         kd = DERIV_GAIN_RST;
         integral = 0;
         prev_err = 0;
         fails = 0;
      endfunction

      function longint sat_add(longint a, longint b);
         logic [64:0] w;
         w = {a[63], a} + {b[63], b};
         if (w[64] != w[63])
            return w[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
         return w[63:0];
      endfunction

      function void set_gain(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
         case (idx)
            CSR_PROP_GAIN: kp = val;
            CSR_INTEG_GAIN: ki = val;
            CSR_DERIV_GAIN: kd = val;
            default: ;
         endcase
      endfunction

      // error that brings the integral back near zero at the current ki
      function longint recentre_error();
         longint q;
         q = integral / longint'(ki);
         if (q > -ERR_BOTTOM) q = -ERR_BOTTOM;
         if (q < -ERR_TOP) q = -ERR_TOP;
         return -q;
      endfunction

      function void take_tick(logic [POS_W-1:0] tgt, logic [POS_W-1:0] meas);
         longint err, sum, lvl, pct;
         drive_duty_type d;
         err = longint'($signed(tgt)) - longint'({32'd0, meas});
         sum = sat_add(longint'(kp) * err + longint'(kd) * (err - prev_err), integral);
         if (sum < 0) begin
            lvl = 0;
         end else begin
            lvl = sum >>> DEF_GAIN_FRAC_BITS;
            if (lvl > DEF_OUTPUT_MAX) lvl = DEF_OUTPUT_MAX;
         end
         pct = lvl * PCT_SCALE / DEF_OUTPUT_MAX;
         d.drive = lvl[DRIVE_OUT_W-1:0];
         d.duty = pct[DUTY_W-1:0];
         drive_due.push_back(d);
         integral = sat_add(integral, longint'(ki) * err);
         prev_err = err;
      endfunction

      function void match_drive(logic [DRIVE_OUT_W-1:0] drive, logic [DUTY_W-1:0] duty);
         drive_duty_type d;
         if (drive_due.size() == 0) begin
            $error("unexpected transfer: drive_level %0d duty_percent %0d", drive, duty);
            fails++;
            return;
         end
         d = drive_due.pop_front();
         if (drive !== d.drive) begin
            $error("drive_level: expected %0d, got %0d", d.drive, drive);
            fails++;
         end
         if (duty !== d.duty) begin
            $error("duty_percent: expected %0d, got %0d", d.duty, duty);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [POS_W-1:0] req_target_position = '0;
   logic [POS_W-1:0] req_measured_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DRIVE_OUT_W-1:0] rsp_drive_level;
   logic [DUTY_W-1:0] rsp_duty_percent;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_write_data = '0;

   pwm_drive_board board = new();
   int sent = 0;
   int snd_idle = 23;
   int rcv_idle = 51;

   logic [POS_W-1:0] dir_tgt [0:16] = '{
      32'd0, 32'd1, 32'd0, 32'd5000, 32'd9000, 32'd10000, 32'd20000, 32'd0,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1000};
   logic [POS_W-1:0] dir_meas [0:16] = '{
      32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3000,
      32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1000};

   pid_position_to_pwm_duty DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_target_position   (req_target_position),
      .req_measured_position (req_measured_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_level       (rsp_drive_level),
      .rsp_duty_percent      (rsp_duty_percent),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.match_drive(rsp_drive_level, rsp_duty_percent);
   end

   // entered and left at a falling edge
   task automatic send_item(input logic [POS_W-1:0] tgt, input logic [POS_W-1:0] meas);
      if (sent < ITEMS_PLANNED / 3) begin
         snd_idle = 23;
         rcv_idle = 51;
      end else if (sent < 2 * ITEMS_PLANNED / 3) begin
         snd_idle = 51;
         rcv_idle = 23;
      end else begin
         snd_idle = 0;
         rcv_idle = 0;
      end
      while ($urandom_range(99) < snd_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_target_position = tgt;
      req_measured_position = meas;
      do @(posedge clock); while (!req_ready);
      board.take_tick(tgt, meas);
      sent++;
      @(negedge clock);
   endtask

   // picks a random target/measured pair that gives this error, clamped to the reachable range
   task automatic send_error(input longint err);
      longint e, lo, hi, t, m;
      logic [31:0] range_u;
      e = err;
      if (e > ERR_TOP) e = ERR_TOP;
      if (e < ERR_BOTTOM) e = ERR_BOTTOM;
      lo = (e > WORD_LOW) ? e : WORD_LOW;
      hi = (WORD_SPAN + e < ERR_TOP) ? WORD_SPAN + e : ERR_TOP;
      range_u = 32'(hi - lo);
      t = lo + longint'($urandom_range(range_u));
      m = t - e;
      send_item(t[31:0], m[31:0]);
   endtask

   function automatic logic [POS_W-1:0] corner_word();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.drive_due.size() != 0) @(negedge clock);
   endtask

   task automatic program_gains(input logic [GAIN_W-1:0] p, i, d);
      csr_write_enable = 1'b1;
      csr_index = CSR_SPARE;
      csr_write_data = GAIN_W'($urandom);
      @(negedge clock);
      csr_index = CSR_PROP_GAIN;
      csr_write_data = p;
      board.set_gain(CSR_PROP_GAIN, p);
      @(negedge clock);
      csr_index = CSR_INTEG_GAIN;
      csr_write_data = i;
      board.set_gain(CSR_INTEG_GAIN, i);
      @(negedge clock);
      csr_index = CSR_DERIV_GAIN;
      csr_write_data = d;
      board.set_gain(CSR_DERIV_GAIN, d);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_phase(input logic [GAIN_W-1:0] p, i, d, input int span, input int count);
      int k;
      int pick;
      wait_drained();
      program_gains(p, GAIN_FULL, d);
      repeat (3) begin
         if (board.integral >= I_SETTLED || board.integral <= -I_SETTLED)
            send_error(board.recentre_error());
      end
      wait_drained();
      program_gains(p, i, d);
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (board.ki != 0 && (board.integral > I_DRIFT || board.integral < -I_DRIFT))
            send_error(board.recentre_error());
         else if (pick < 70)
            send_error(longint'($urandom_range(2 * span)) - span);
         else if (pick < 85)
            send_item($urandom, $urandom);
         else
            send_item(corner_word(), corner_word());
      end
   endtask

   initial begin
      int k;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // spare index first: must leave the reset gains alone
      csr_write_enable = 1'b1;
      csr_index = CSR_SPARE;
      csr_write_data = GAIN_FULL;
      @(negedge clock);
      csr_write_enable = 1'b0;
      for (k = 0; k <= 16; k++)
         send_item(dir_tgt[k], dir_meas[k]);

      run_phase(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, 12000, 70);
      run_phase(GAIN_FULL, '0, '0, 80, 45);
      run_phase('0, '0, GAIN_FULL, 80, 45);
      run_phase('0, GAIN_FULL, '0, 60, 55);
      run_phase('0, '0, '0, 1000, 15);
      run_phase(GAIN_W'($urandom_range(24'h3F_FFFF)), GAIN_W'($urandom_range(24'h00_FFFF)),
                GAIN_W'($urandom_range(24'h3F_FFFF)), 20000, 55);
      run_phase(24'd1, 24'd1, 24'd1, 1 << 30, 35);

      // integral into positive saturation, then down to negative saturation
      wait_drained();
      program_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL);
      repeat (270) send_error(ERR_TOP - longint'($urandom_range(255)));
      repeat (185) send_error(ERR_BOTTOM + longint'($urandom_range(255)));

      wait_drained();
      repeat (12) @(negedge clock);
      if (board.fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

[pid_position_to_pwm_duty.f]
hdl/ppwm_pkg.sv
hdl/ppwm_front.sv
hdl/ppwm_queue.sv
hdl/ppwm_back.sv
hdl/pid_position_to_pwm_duty.sv
test/tb_pid_position_to_pwm_duty.sv
